/* src/mwts_pkg.sv */
// Shared constants, register codes and transaction types for the weighted target selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package mwts_pkg;

	// Sizing
	localparam int MAX_TARGETS = 4;
	localparam int FREE_BITS   = 48;
	localparam int SLOTS       = 4;
	localparam int SLOT_W      = 2;
	localparam int CNT_W       = 3;
	localparam int ID_W        = 4;
	localparam int FIELD_W     = 48;
	localparam int CAP_W       = (FREE_BITS < FIELD_W) ? FREE_BITS : FIELD_W;
	localparam int SUM_W       = CAP_W + 2;
	localparam int CTR_W       = 64;
	localparam int DIV_W       = 64;
	localparam int STEP_W      = $clog2(DIV_W);
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_TARGET_COUNT = 3'd0;
	localparam logic [2:0] REG_TARGET_ID_0  = 3'd1;
	localparam logic [2:0] REG_TARGET_ID_1  = 3'd2;
	localparam logic [2:0] REG_TARGET_ID_2  = 3'd3;
	localparam logic [2:0] REG_TARGET_ID_3  = 3'd4;

	// Request actions
	localparam logic ACT_SELECT    = 1'b0;
	localparam logic ACT_NEW_QUERY = 1'b1;

	typedef struct packed {
		logic               action;
		logic [FIELD_W-1:0] free_0;
		logic [FIELD_W-1:0] free_1;
		logic [FIELD_W-1:0] free_2;
		logic [FIELD_W-1:0] free_3;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   chosen_id;
		logic [SLOT_W-1:0] chosen_slot;
		logic              used_fallback;
	} rsp_t;

endpackage

`default_nettype wire

/* src/mwts_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W steps per operation.
// Depends on mwts_pkg for DIV_W and STEP_W.
`default_nettype none

module mwts_div import mwts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W+1:0]  diff;
	logic              fits;
	logic              last_step;

	// Trial subtract of the divisor from the shifted partial remainder
	assign diff      = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};
	assign fits      = ~diff[DIV_W+1];
	assign last_step = (step_q == STEP_W'(DIV_W - 1));

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q & ~go & last_step;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift dividend bits out into the remainder, shift quotient bits in
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* src/memory_weighted_target_selector_core.sv */
// Top level of the weighted target selector: APB registers, sequencer and serial datapath.
// Depends on mwts_pkg and instantiates mwts_div.
//
//   channel   direction  handshake                   payload
//   req       in         req_valid / req_ready       req_t  (action, free_0..free_3)
//   rsp       out        rsp_valid / rsp_ready       rsp_t  (chosen_id, chosen_slot, used_fallback)
//   apb       in         psel / penable / pready     paddr, pwdata, prdata
//
// A new-query transaction clears the pick counter; a select with zero or one target goes
// straight to output. A weighted select sums the slots, runs the serial divider for the
// stride, multiplies it by the pick counter in radix-4 steps that end early once the
// counter bits run out, runs the divider for the position and walks the slots to output.
// The fallback path runs one divider pass. One transaction is in flight at a time;
// a result waits in the output register and stalls only the finishing step. Reset is
// asynchronous: pick counter, target count and control state clear; ids reset to 0..3.
`default_nettype none

module memory_weighted_target_selector_core import mwts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SUM    = 3'd1;
	localparam logic [2:0] S_FBDIV  = 3'd2;
	localparam logic [2:0] S_STRIDE = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_MOD    = 3'd5;
	localparam logic [2:0] S_WALK   = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	// Configuration
	logic [CNT_W-1:0] target_count_q;
	logic [ID_W-1:0]  target_id_q [SLOTS];
	logic             cfg_wr;
	logic [2:0]       cfg_idx;

	// Control
	logic [2:0]        state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              found_q;
	logic              div_go_q;
	logic [CTR_W-1:0]  counter_q;
	logic              rsp_valid_q;

	// Datapath
	logic [CNT_W-1:0]  n_q;
	logic [CAP_W-1:0]  cap_q [SLOTS];
	logic [SUM_W-1:0]  total_q;
	logic [CAP_W-1:0]  least_q;
	logic [CTR_W-1:0]  mcand_q;
	logic [CTR_W-1:0]  mcand3_q;
	logic [CTR_W-1:0]  mplier_q;
	logic [CTR_W-1:0]  acc_q;
	logic [SUM_W-1:0]  pos_q;
	logic [SUM_W-1:0]  run_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_fb_q;
	logic              res_none_q;
	rsp_t              rsp_q;

	// Combinational
	logic [CNT_W-1:0]  n_use;
	logic              accept;
	logic              in_use;
	logic              last_idx;
	logic [SUM_W-1:0]  total_nxt;
	logic [CAP_W-1:0]  least_nxt;
	logic [SUM_W-1:0]  run_nxt;
	logic              hit;
	logic [CTR_W-1:0]  digit;
	logic [CAP_W-1:0]  stride;
	logic [CAP_W+1:0]  stride3;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [DIV_W-1:0]  div_rem;
	logic              rsp_load;

	// Register file
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_count_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				target_id_q[i] <= ID_W'(i);
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TARGET_COUNT: target_count_q <= pwdata[CNT_W-1:0];
				REG_TARGET_ID_0:  target_id_q[0] <= pwdata[ID_W-1:0];
				REG_TARGET_ID_1:  target_id_q[1] <= pwdata[ID_W-1:0];
				REG_TARGET_ID_2:  target_id_q[2] <= pwdata[ID_W-1:0];
				REG_TARGET_ID_3:  target_id_q[3] <= pwdata[ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_TARGET_COUNT: prdata = PDATA_W'(target_count_q);
			REG_TARGET_ID_0:  prdata = PDATA_W'(target_id_q[0]);
			REG_TARGET_ID_1:  prdata = PDATA_W'(target_id_q[1]);
			REG_TARGET_ID_2:  prdata = PDATA_W'(target_id_q[2]);
			REG_TARGET_ID_3:  prdata = PDATA_W'(target_id_q[3]);
			default:          prdata = '0;
		endcase
	end

	// Clamp the target count to the slots that exist
	always_comb begin
		n_use = target_count_q;
		if (int'(n_use) > MAX_TARGETS) n_use = CNT_W'(MAX_TARGETS);
		if (int'(n_use) > SLOTS) n_use = CNT_W'(SLOTS);
	end

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;

	// Per-slot step: the current slot always sits in cap_q[0]
	assign in_use    = ({1'b0, idx_q} < n_q);
	assign last_idx  = (idx_q == SLOT_W'(SLOTS - 1));
	assign total_nxt = total_q + (in_use ? SUM_W'(cap_q[0]) : '0);
	assign least_nxt = (in_use && (cap_q[0] < least_q)) ? cap_q[0] : least_q;
	assign run_nxt   = run_q + SUM_W'(cap_q[0]);
	assign hit       = in_use & ~found_q & (pos_q < run_nxt);

	// Radix-4 multiplier digit select
	always_comb begin
		unique case (mplier_q[1:0])
			2'd0:    digit = '0;
			2'd1:    digit = mcand_q;
			2'd2:    digit = {mcand_q[CTR_W-2:0], 1'b0};
			default: digit = mcand3_q;
		endcase
	end

	// Stride is at least one
	assign stride  = (div_quo[CAP_W-1:0] == '0) ? CAP_W'(1) : div_quo[CAP_W-1:0];
	assign stride3 = {1'b0, stride, 1'b0} + {2'b00, stride};

	// Divider operands follow the state that owns the divider
	always_comb begin
		unique case (state_q)
			S_FBDIV: begin
				div_dividend = counter_q;
				div_divisor  = DIV_W'(n_q);
			end
			S_STRIDE: begin
				div_dividend = DIV_W'(least_q);
				div_divisor  = DIV_W'(n_q);
			end
			default: begin
				div_dividend = acc_q;
				div_divisor  = DIV_W'(total_q);
			end
		endcase
	end

	mwts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go_q),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign rsp_load = (state_q == S_EMIT) & (~rsp_valid_q | rsp_ready);

	// Sequencer and pick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			div_go_q    <= 1'b0;
			counter_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Pulse the divider start when a pass is due
			div_go_q <= ((state_q == S_SUM) & last_idx) |
				((state_q == S_MUL) & (mplier_q == '0));
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.action == ACT_NEW_QUERY) begin
							counter_q <= '0;
						end else if (n_use <= CNT_W'(1)) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SUM;
							idx_q   <= '0;
						end
					end
				end
				S_SUM: begin
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						state_q <= (total_nxt == '0) ? S_FBDIV : S_STRIDE;
					end
				end
				S_FBDIV: begin
					if (div_done) begin
						counter_q <= counter_q + 1'b1;
						state_q   <= S_EMIT;
					end
				end
				S_STRIDE: begin
					if (div_done) state_q <= S_MUL;
				end
				S_MUL: begin
					if (mplier_q == '0) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_done) begin
						state_q <= S_WALK;
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (hit) found_q <= 1'b1;
					if (last_idx) begin
						counter_q <= counter_q + 1'b1;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rsp_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// Hold the result until taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					n_q        <= n_use;
					cap_q[0]   <= req.free_0[CAP_W-1:0];
					cap_q[1]   <= req.free_1[CAP_W-1:0];
					cap_q[2]   <= req.free_2[CAP_W-1:0];
					cap_q[3]   <= req.free_3[CAP_W-1:0];
					total_q    <= '0;
					least_q    <= '1;
					res_slot_q <= '0;
					res_fb_q   <= 1'b0;
					res_none_q <= (n_use == '0);
				end
			end
			S_SUM: begin
				total_q <= total_nxt;
				least_q <= least_nxt;
				for (int i = 0; i < SLOTS - 1; i++) begin
					cap_q[i] <= cap_q[i+1];
				end
				cap_q[SLOTS-1] <= cap_q[0];
			end
			S_FBDIV: begin
				if (div_done) begin
					res_slot_q <= div_rem[SLOT_W-1:0];
					res_fb_q   <= 1'b1;
				end
			end
			S_STRIDE: begin
				if (div_done) begin
					mcand_q  <= CTR_W'(stride);
					mcand3_q <= CTR_W'(stride3);
					mplier_q <= counter_q;
					acc_q    <= '0;
				end
			end
			S_MUL: begin
				if (mplier_q != '0) begin
					acc_q    <= acc_q + digit;
					mplier_q <= mplier_q >> 2;
					mcand_q  <= mcand_q << 2;
					mcand3_q <= mcand3_q << 2;
				end
			end
			S_MOD: begin
				if (div_done) begin
					pos_q <= div_rem[SUM_W-1:0];
					run_q <= '0;
				end
			end
			S_WALK: begin
				run_q <= run_nxt;
				for (int i = 0; i < SLOTS - 1; i++) begin
					cap_q[i] <= cap_q[i+1];
				end
				cap_q[SLOTS-1] <= cap_q[0];
				if (hit) begin
					res_slot_q <= idx_q;
				end else if (last_idx && !found_q) begin
					res_slot_q <= SLOT_W'(n_q - 1'b1);
				end
			end
			S_EMIT: begin
				if (rsp_load) begin
					rsp_q.chosen_id     <= res_none_q ? '0 : target_id_q[res_slot_q];
					rsp_q.chosen_slot   <= res_slot_q;
					rsp_q.used_fallback <= res_fb_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* src/mwts_checker.sv */
// Port-level checks for the weighted target selector, bound to the top level.
// Depends on mwts_pkg for port types.
`default_nettype none

module mwts_checker import mwts_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [PDATA_W-1:0] pwdata,
	input wire logic [PDATA_W-1:0] prdata,
	input wire logic               pready,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire req_t               req,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire rsp_t               rsp
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	// A new query clears the counter and leaves the block ready
	a_newq_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.action == ACT_NEW_QUERY |=> req_ready)
		else $error("block busy after a new-query transaction");

	// A select transaction leaves the block not ready in the cycle after it is accepted
	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.action == ACT_SELECT |=> !req_ready)
		else $error("block ready right after a select transaction");

	// A fresh result is only produced while a select is in flight
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while the block was idle");

endmodule

bind memory_weighted_target_selector_core mwts_checker u_mwts_checker (.*);

`default_nettype wire

/* tb/sv/memory_weighted_target_selector_core_tb.sv */
// Self-checking testbench for memory_weighted_target_selector_core: directed table, then
// randomized select/new-query traffic over several register settings, checked by a predictor.
// Depends on mwts_pkg and the core RTL.
`default_nettype none

module memory_weighted_target_selector_core_tb;
	import mwts_pkg::*;

	localparam logic [47:0] CAP_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] FREE_MASK = (64'd1 << FREE_BITS) - 64'd1;
	localparam int SETTLE_CYCLES = 200;
	localparam int RAND_PHASES   = 9;
	localparam int PHASE_ITEMS   = 112;
	localparam int HOLD_AT_PICK  = 250;
	localparam int HOLD_CYCLES   = 800;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_ready;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_ready;
	rsp_t               rsp;

	memory_weighted_target_selector_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Directed stimulus row: register setting, request, and optionally a typed-in answer
	typedef struct {
		logic [2:0]  count;
		logic [15:0] ids;
		req_t        item;
		bit          typed;
		rsp_t        want;
	} pick_row_t;

	// Selector shadow state
	logic [63:0] pick_ctr;
	logic [2:0]  cfg_count;
	logic [3:0]  cfg_id [SLOTS];

	pick_row_t   pick_rows [$];
	rsp_t        expected_picks [$];
	rsp_t        head_pick;
	int          picks_seen;
	int          errors;
	int          items_sent;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predict one transaction; returns 1 when a result is due
	function automatic bit predict_pick(input req_t r, output rsp_t o);
		logic [63:0] cap [SLOTS];
		logic [63:0] total;
		logic [63:0] least;
		logic [63:0] stride;
		logic [63:0] prod;
		logic [63:0] pos;
		logic [63:0] run;
		int          n;
		int          slot;
		bit          found;
		bit          fb;
		o = '0;
		if (r.action == ACT_NEW_QUERY) begin
			pick_ctr = '0;
			return 1'b0;
		end
		n = int'(cfg_count);
		if (n > MAX_TARGETS) n = MAX_TARGETS;
		if (n > SLOTS) n = SLOTS;
		if (n <= 1) begin
			o.chosen_id = (n == 0) ? '0 : cfg_id[0];
			return 1'b1;
		end
		cap[0] = 64'(r.free_0) & FREE_MASK;
		cap[1] = 64'(r.free_1) & FREE_MASK;
		cap[2] = 64'(r.free_2) & FREE_MASK;
		cap[3] = 64'(r.free_3) & FREE_MASK;
		total = '0;
		least = '1;
		for (int i = 0; i < n; i++) begin
			total = total + cap[i];
			if (cap[i] < least) least = cap[i];
		end
		fb = 1'b0;
		if (total == 0) begin
			slot = int'(pick_ctr % 64'(n));
			fb = 1'b1;
		end else begin
			stride = least / 64'(n);
			if (stride == 0) stride = 64'd1;
			prod = pick_ctr * stride;
			pos = prod % total;
			run = '0;
			slot = n - 1;
			found = 1'b0;
			for (int i = 0; i < n; i++) begin
				run = run + cap[i];
				if (!found && pos < run) begin
					slot = i;
					found = 1'b1;
				end
			end
		end
		pick_ctr = pick_ctr + 64'd1;
		o.chosen_id = cfg_id[slot];
		o.chosen_slot = slot[SLOT_W-1:0];
		o.used_fallback = fb;
		return 1'b1;
	endfunction

	function automatic logic [47:0] rand_cap();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic add_row(input logic [2:0] count, input logic [15:0] ids, input logic action,
			input logic [47:0] f0, input logic [47:0] f1, input logic [47:0] f2,
			input logic [47:0] f3, input bit typed, input logic [3:0] id,
			input logic [1:0] slot, input logic fb);
		pick_row_t row;
		row.count = count;
		row.ids = ids;
		row.item = '{action: action, free_0: f0, free_1: f1, free_2: f2, free_3: f3};
		row.typed = typed;
		row.want = '{chosen_id: id, chosen_slot: slot, used_fallback: fb};
		pick_rows.insert(pick_rows.size(), row);
	endtask

	// APB write: setup cycle, access cycle, then release the bus
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_TARGET_COUNT)
			cfg_count = val[2:0];
		else
			cfg_id[int'(idx) - 1] = val[3:0];
	endtask

	// Drain outstanding results, let a trailing new query finish, then reprogram
	task automatic apply_config(input logic [2:0] count, input logic [15:0] ids, input bit all);
		while (expected_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (all || count != cfg_count) write_reg(REG_TARGET_COUNT, PDATA_W'(count));
		if (all || ids[3:0] != cfg_id[0]) write_reg(REG_TARGET_ID_0, PDATA_W'(ids[3:0]));
		if (all || ids[7:4] != cfg_id[1]) write_reg(REG_TARGET_ID_1, PDATA_W'(ids[7:4]));
		if (all || ids[11:8] != cfg_id[2]) write_reg(REG_TARGET_ID_2, PDATA_W'(ids[11:8]));
		if (all || ids[15:12] != cfg_id[3]) write_reg(REG_TARGET_ID_3, PDATA_W'(ids[15:12]));
	endtask

	// Offer one transaction, hold it until accepted, then queue its expected pick
	task automatic offer(input req_t r, input bit typed, input rsp_t want);
		rsp_t got;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		if (predict_pick(r, got))
			expected_picks.insert(expected_picks.size(), typed ? want : got);
	endtask

	// Randomly drop valid between transactions, except in a quiet stretch
	task automatic sender_gap(input int idx);
		int gap;
		if ((idx < 300 || idx >= 450) && $urandom_range(0, 99) < 14) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic req_t rand_item();
		req_t  r;
		logic [47:0] v;
		r = '0;
		r.action = ($urandom_range(0, 99) < 5) ? ACT_NEW_QUERY : ACT_SELECT;
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				r.free_0 = rand_cap(); r.free_1 = rand_cap();
				r.free_2 = rand_cap(); r.free_3 = rand_cap();
			end
			2: begin
				r.free_0 = 48'($urandom_range(0, 15)); r.free_1 = 48'($urandom_range(0, 15));
				r.free_2 = 48'($urandom_range(0, 15)); r.free_3 = 48'($urandom_range(0, 15));
			end
			3: begin
				r.free_0 = CAP_MAX - 48'($urandom_range(0, 3));
				r.free_1 = CAP_MAX - 48'($urandom_range(0, 3));
				r.free_2 = CAP_MAX - 48'($urandom_range(0, 3));
				r.free_3 = CAP_MAX - 48'($urandom_range(0, 3));
			end
			4: begin
				r.free_0 = $urandom_range(0, 1) ? rand_cap() : '0;
				r.free_1 = $urandom_range(0, 1) ? rand_cap() : '0;
				r.free_2 = $urandom_range(0, 1) ? rand_cap() : '0;
				r.free_3 = $urandom_range(0, 1) ? rand_cap() : '0;
			end
			default: begin
				v = rand_cap() >> $urandom_range(0, 40);
				r.free_0 = v; r.free_1 = v; r.free_2 = v; r.free_3 = v;
			end
		endcase
		return r;
	endfunction

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			picks_seen++;
			if (expected_picks.size() == 0) begin
				errors++;
				$error("result with no transaction pending: id %0d slot %0d fallback %0d",
					rsp.chosen_id, rsp.chosen_slot, rsp.used_fallback);
			end else begin
				head_pick = expected_picks.pop_front();
				if (rsp.chosen_id !== head_pick.chosen_id) begin
					errors++;
					$error("chosen_id: expected %0d, got %0d", head_pick.chosen_id, rsp.chosen_id);
				end
				if (rsp.chosen_slot !== head_pick.chosen_slot) begin
					errors++;
					$error("chosen_slot: expected %0d, got %0d",
						head_pick.chosen_slot, rsp.chosen_slot);
				end
				if (rsp.used_fallback !== head_pick.used_fallback) begin
					errors++;
					$error("used_fallback: expected %0d, got %0d",
						head_pick.used_fallback, rsp.used_fallback);
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a quiet stretch
	initial begin
		bit held;
		held = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && picks_seen >= HOLD_AT_PICK) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_ready <= 1'b1;
			end else if (picks_seen >= 500 && picks_seen < 650) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// Hard stop
	initial begin
		#10_000_000;
		$display("FAIL memory_weighted_target_selector_core");
		$finish;
	end

	initial begin
		logic [2:0]  count;
		logic [15:0] ids;
		int          k;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		req_valid  = 1'b0;
		req        = '0;
		pick_ctr   = '0;
		cfg_count  = '0;
		for (int i = 0; i < SLOTS; i++) cfg_id[i] = 4'(i);
		picks_seen = 0;
		errors     = 0;
		items_sent = 0;

		// Directed table: count, ids {3,2,1,0}, action, free_0..3, typed, id, slot, fallback
		add_row(3'd0, 16'h3210, ACT_SELECT, '0, '0, '0, '0, 1, 4'h0, 2'd0, 1'b0);
		add_row(3'd0, 16'h3210, ACT_SELECT, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX,
			1, 4'h0, 2'd0, 1'b0);
		add_row(3'd1, 16'h321F, ACT_SELECT, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX,
			1, 4'hF, 2'd0, 1'b0);
		add_row(3'd1, 16'h321F, ACT_NEW_QUERY, '0, '0, '0, '0, 1, 4'h0, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_NEW_QUERY, '0, '0, '0, '0, 1, 4'h0, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 1, 4'h1, 2'd0, 1'b1);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 1, 4'hA, 2'd1, 1'b1);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 1, 4'h6, 2'd2, 1'b1);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 1, 4'hE, 2'd3, 1'b1);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 1, 4'h1, 2'd0, 1'b1);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX,
			0, 4'h0, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, 48'd1, '0, '0, '0, 1, 4'h1, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, '0, '0, '0, CAP_MAX, 1, 4'hE, 2'd3, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, 48'd100, 48'd200, 48'd300, 48'd400,
			0, 4'h0, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_NEW_QUERY, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX,
			1, 4'h0, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, 48'd10, 48'd10, 48'd10, 48'd10, 1, 4'h1, 2'd0, 1'b0);
		add_row(3'd4, 16'hE6A1, ACT_SELECT, CAP_MAX, 48'd1, CAP_MAX, 48'd1, 0, 4'h0, 2'd0, 1'b0);
		// count above range behaves as four targets
		add_row(3'd7, 16'hE6A1, ACT_SELECT, '0, '0, '0, '0, 0, 4'h0, 2'd0, 1'b0);
		add_row(3'd7, 16'hE6A1, ACT_SELECT, 48'd5, 48'd6, 48'd7, 48'd8, 0, 4'h0, 2'd0, 1'b0);
		add_row(3'd2, 16'h00F0, ACT_SELECT, '0, '0, CAP_MAX, CAP_MAX, 0, 4'h0, 2'd0, 1'b0);
		add_row(3'd2, 16'h00F0, ACT_SELECT, '0, CAP_MAX, '0, '0, 1, 4'hF, 2'd1, 1'b0);
		add_row(3'd2, 16'h00F0, ACT_SELECT, CAP_MAX, 48'h8000_0000_0000, '0, '0,
			0, 4'h0, 2'd0, 1'b0);
		add_row(3'd3, 16'h0000, ACT_SELECT, 48'd7, 48'd7, 48'd7, CAP_MAX, 0, 4'h0, 2'd0, 1'b0);
		add_row(3'd3, 16'h0000, ACT_SELECT, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'd3, '0,
			0, 4'h0, 2'd0, 1'b0);

		// Hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (pick_rows[i]) begin
			if (pick_rows[i].count != cfg_count ||
					pick_rows[i].ids != {cfg_id[3], cfg_id[2], cfg_id[1], cfg_id[0]}) begin
				@(negedge clk);
				req_valid <= 1'b0;
				apply_config(pick_rows[i].count, pick_rows[i].ids, 1'b0);
			end
			offer(pick_rows[i].item, pick_rows[i].typed, pick_rows[i].want);
			sender_gap(-1);
		end

		// Random phases, each with a fresh register setting
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin count = 3'd4; ids = 16'hFFFF; end
				1: begin count = 3'd2; ids = 16'h0000; end
				2: begin count = 3'd7; ids = 16'($urandom); end
				3: begin count = 3'd3; ids = 16'($urandom); end
				default: begin
					count = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(2, 4))
						: 3'($urandom_range(0, 7));
					ids = 16'($urandom);
				end
			endcase
			@(negedge clk);
			req_valid <= 1'b0;
			apply_config(count, ids, 1'b1);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				offer(rand_item(), 1'b0, '0);
				sender_gap(p * PHASE_ITEMS + j);
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Drain with a bound, then let the pipeline go quiet
		k = 0;
		while (expected_picks.size() != 0 && k < 50_000) begin
			@(posedge clk);
			k++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_picks.size() != 0) begin
			errors++;
			$error("%0d expected results never arrived", expected_picks.size());
		end
		if (errors == 0)
			$display("PASS memory_weighted_target_selector_core");
		else
			$display("FAIL memory_weighted_target_selector_core");
		$finish;
	end

endmodule

`default_nettype wire
